// ===== sv/aarr_pkg.sv =====
// Shared types, codes and compare helpers for the argmax/argmin row reduction.
package aarr_pkg;

  localparam int ValueWidth = 64;
  localparam int IndexWidth = 16;
  localparam int LenWidth   = 17;
  localparam int TypeWidth  = 3;

  typedef enum logic [1:0] {
    CFG_MAX_MODE     = 2'd0,
    CFG_ELEMENT_TYPE = 2'd1,
    CFG_ROW_LENGTH   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ET_INT8  = 3'd0,
    ET_INT16 = 3'd1,
    ET_INT32 = 3'd2,
    ET_INT64 = 3'd3,
    ET_FP32  = 3'd4,
    ET_FP64  = 3'd5,
    ET_RSV6  = 3'd6,
    ET_RSV7  = 3'd7
  } elem_type_t;

  typedef struct packed {
    logic       max_mode;
    elem_type_t etype;
  } cmp_ctrl_t;

  // Mask raw bits down to the element width.
  function automatic logic [63:0] mask_value(input logic [63:0] x, input elem_type_t t);
    case (t)
      ET_INT8:          mask_value = {56'd0, x[7:0]};
      ET_INT16:         mask_value = {48'd0, x[15:0]};
      ET_INT32, ET_FP32: mask_value = {32'd0, x[31:0]};
      default:          mask_value = x;
    endcase
  endfunction

  function automatic logic [63:0] init_extreme(input logic mx, input elem_type_t t);
    case (t)
      ET_INT8:  init_extreme = mx ? 64'h80 : 64'h7F;
      ET_INT16: init_extreme = mx ? 64'h8000 : 64'h7FFF;
      ET_INT32: init_extreme = mx ? 64'h8000_0000 : 64'h7FFF_FFFF;
      ET_FP32:  init_extreme = mx ? 64'hFF80_0000 : 64'h7F80_0000;
      ET_FP64:  init_extreme = mx ? 64'hFFF0_0000_0000_0000 : 64'h7FF0_0000_0000_0000;
      default:  init_extreme = mx ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

endpackage

// ===== sv/aarr_if.sv =====
// Valid/ready stream interface carrying one payload word per beat.
interface aarr_if #(parameter int W = 64) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/aarr_cmp.sv =====
// Strict better-than compare of two element bit patterns under the current type and mode.
module aarr_cmp import aarr_pkg::*; (
  input  cmp_ctrl_t   ctrl,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        better
);
  logic [63:0] ka, kb;
  logic        a_nan, b_nan, a_zero, b_zero;
  logic        gt, lt;

  // Map each type to an unsigned order key; floats flip on sign.
  function automatic logic [63:0] key(input logic [63:0] x, input elem_type_t t);
    case (t)
      ET_INT8:  key = {~x[7], {56{x[7]}}, x[6:0]};
      ET_INT16: key = {~x[15], {48{x[15]}}, x[14:0]};
      ET_INT32: key = {~x[31], {32{x[31]}}, x[30:0]};
      ET_FP32:  key = x[31] ? {32'd0, ~x[31:0]} : {32'd0, 1'b1, x[30:0]};
      ET_FP64:  key = x[63] ? ~x : {1'b1, x[62:0]};
      default:  key = {~x[63], x[62:0]};
    endcase
  endfunction

  always_comb begin
    ka = key(a, ctrl.etype);
    kb = key(b, ctrl.etype);
    a_nan = 1'b0; b_nan = 1'b0; a_zero = 1'b0; b_zero = 1'b0;
    if (ctrl.etype == ET_FP32) begin
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      a_zero = a[30:0] == '0;
      b_zero = b[30:0] == '0;
    end else if (ctrl.etype == ET_FP64) begin
      a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
      b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
      a_zero = a[62:0] == '0;
      b_zero = b[62:0] == '0;
    end
    gt = ka > kb;
    lt = ka < kb;
    if (a_nan || b_nan || (a_zero && b_zero)) better = 1'b0;
    else better = ctrl.max_mode ? gt : lt;
  end
endmodule

// ===== sv/argmax_argmin_row_reduce_core.sv =====
// Top level: streaming argmax/argmin over configured-length rows.
// One element is taken per cycle. Each beat is captured in an input register, compared
// against the running best in one compare stage, and the index of a finished row goes to
// a result register; with the output taken every cycle the block sustains one element per
// clock; it stalls only when a row ends while the previous index waits at the output.
module argmax_argmin_row_reduce_core import aarr_pkg::*; #(
  parameter int MAX_ROW_LENGTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  aarr_if.sink        in_ch,
  aarr_if.source      out_ch
);
  localparam logic [LenWidth:0] MaxLen = (LenWidth+1)'(MAX_ROW_LENGTH > 65536 ? 65536
                                                     : MAX_ROW_LENGTH);

  logic              max_mode_r;
  elem_type_t        etype_r;
  logic [16:0]       row_len_r;

  logic              in_vld_r;
  logic [63:0]       in_val_r;
  logic [63:0]       best_val_r, best_val_nxt;
  logic [15:0]       best_pos_r, best_pos_nxt;
  logic [16:0]       cnt_r, cnt_nxt;
  logic              out_vld_r;
  logic [15:0]       out_idx_r;

  logic [LenWidth:0] eff_len;
  logic [63:0]       v, cur_best;
  logic              better, row_end, stall, in_fire;
  cmp_ctrl_t         ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mode_r <= 1'b1;
      etype_r    <= ET_INT32;
      row_len_r  <= 17'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_MODE:     max_mode_r <= cfg_wdata[0];
        CFG_ELEMENT_TYPE: etype_r    <= elem_type_t'(cfg_wdata[2:0]);
        CFG_ROW_LENGTH:   row_len_r  <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  assign ctrl  = '{max_mode: max_mode_r, etype: etype_r};
  // Hold the stage when a row finishes and the previous index is still waiting.
  assign stall = in_vld_r && row_end && out_vld_r && !out_ch.ready;
  assign in_ch.ready = !stall;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    if (row_len_r == '0) eff_len = (LenWidth+1)'(1);
    else if ({1'b0, row_len_r} > MaxLen) eff_len = MaxLen;
    else eff_len = {1'b0, row_len_r};
  end

  assign v        = mask_value(in_val_r, etype_r);
  assign cur_best = (cnt_r == '0) ? init_extreme(max_mode_r, etype_r) : best_val_r;

  aarr_cmp u_cmp (.ctrl(ctrl), .a(v), .b(cur_best), .better(better));

  assign row_end = ({1'b0, cnt_r} + (LenWidth+1)'(1)) >= eff_len;

  always_comb begin
    best_val_nxt = better ? v : cur_best;
    best_pos_nxt = better ? cnt_r[15:0] : ((cnt_r == '0) ? '0 : best_pos_r);
    cnt_nxt      = row_end ? '0 : cnt_r + 17'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
      best_pos_r <= '0;
      best_val_r <= 64'h8000_0000;
    end else begin
      if (out_vld_r && out_ch.ready) out_vld_r <= 1'b0;
      if (in_vld_r && !stall) begin
        best_val_r <= best_val_nxt;
        best_pos_r <= best_pos_nxt;
        cnt_r      <= cnt_nxt;
        if (row_end) out_vld_r <= 1'b1;
      end
      if (!stall) in_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) in_val_r <= in_ch.data;
    if (in_vld_r && !stall && row_end) out_idx_r <= best_pos_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_idx_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(cnt_r)) else $error("counter moved while stalled");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} < MaxLen) else $error("element counter out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_idx_r))
    else $error("pending index lost");
endmodule
